### design/tick_process_scheduler_macros.svh
// assertion helpers for the scheduler, clocked on clk and held off during reset
`ifndef TICK_PROCESS_SCHEDULER_MACROS_SVH
`define TICK_PROCESS_SCHEDULER_MACROS_SVH

// same-cycle implication
`define TPS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tick_process_scheduler: same-cycle check failed");

// next-cycle implication
`define TPS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tick_process_scheduler: next-cycle check failed");

`endif

### design/tps_pkg.sv
`timescale 1ns / 1ps

package tps_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int TIME_BITS = 24;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  localparam int POLICY_W   = 2;
  localparam int NSLOT_W    = 5;
  localparam int QUANTUM_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DONE_W     = 5;

  localparam logic [DONE_W-1:0] DONE_MAX = '1;

  localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
  localparam logic [POLICY_W-1:0] POL_RR   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_SJF  = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SLOTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RETIRE,
    S_MOD,
    S_SCAN,
    S_PICK,
    S_UPD,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic              clr;
    logic              ev;
    logic [SLOT_W-1:0] idx;
    logic              arrived_old;
    logic              by_rem;
    logic [CNT_W-1:0]  start;
  } scan_ctl_t;

  typedef struct packed {
    logic              arrived_new;
    logic              found;
    logic [SLOT_W-1:0] best_idx;
    logic              any_found;
    logic [SLOT_W-1:0] first_any;
    logic              ge_found;
    logic [SLOT_W-1:0] first_ge;
  } scan_res_t;

endpackage

### design/tick_process_scheduler.sv
// tick_process_scheduler: tick-driven process scheduler over a table of slots
// commands enter on start/busy; a transaction is taken when start is high and
// busy is low. a load writes one slot and its result strobes on the next cycle
// without raising busy. a tick raises busy through a sequence of steps, n
// being the slots in use: a retire step, the rotation start reduced modulo n
// by repeated subtraction, a sweep of the slot tables through their single
// read port into the shared compare unit, a pick step and an update step.
// once every slot has finished a tick only reports. each result sits on
// the out_ ports for exactly one
// cycle with out_strobe high; the receiver cannot stall it, and a new command
// may start the cycle the strobe shows. configuration writes on cfg_we take
// effect at once and belong in idle periods. reset clears time, counters, the
// running slot and all arrived flags and loads policy 0, one slot, quantum 500;
// the slot tables are undefined until loaded.
`timescale 1ns / 1ps

`include "tick_process_scheduler_macros.svh"

module tick_process_scheduler import tps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [TIME_BITS-1:0]  in_arrival_tick,
  input  logic [TIME_BITS-1:0]  in_run_length,
  output logic                  out_strobe,
  output logic                  out_running_valid,
  output logic [SLOT_W-1:0]     out_running_slot,
  output logic                  out_finished_valid,
  output logic [SLOT_W-1:0]     out_finished_slot,
  output logic                  out_all_done,
  output logic [TIME_BITS-1:0]  out_time_now,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [POLICY_W-1:0]  policy_r;
  logic [NSLOT_W-1:0]   num_r;
  logic [QUANTUM_W-1:0] quantum_r;

  logic [MAX_SLOTS-1:0] arrived_r, arrived_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic                 cv_r, cv_nxt;
  logic [SLOT_W-1:0]    cs_r, cs_nxt;
  logic [QUANTUM_W-1:0] slice_r, slice_nxt;
  logic [DONE_W-1:0]    done_r, done_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 ev_r, ev_nxt;
  logic [SLOT_W-1:0]    ev_idx_r, ev_idx_nxt;
  logic [CNT_W-1:0]     m_r, m_nxt;
  logic                 fin_valid_r, fin_valid_nxt;
  logic [SLOT_W-1:0]    fin_slot_r, fin_slot_nxt;

  logic                 strobe_r, strobe_nxt;
  logic                 rv_r, rv_nxt;
  logic [SLOT_W-1:0]    rs_r, rs_nxt;
  logic                 fv_r, fv_nxt;
  logic [SLOT_W-1:0]    fs_r, fs_nxt;
  logic                 ad_r, ad_nxt;
  logic [TIME_BITS-1:0] tn_r, tn_nxt;

  logic [CNT_W-1:0]     n;
  logic [QUANTUM_W-1:0] q;
  logic                 all_done_now;
  logic [DONE_W-1:0]    done_after;
  logic                 retiring;
  logic                 pick_ok;
  logic [SLOT_W-1:0]    pick;
  logic [QUANTUM_W-1:0] slice_base;

  logic                 arr_we;
  logic                 rem_we;
  logic [SLOT_W-1:0]    arr_waddr;
  logic [SLOT_W-1:0]    rem_waddr;
  logic [TIME_BITS-1:0] rem_wdata;
  logic [SLOT_W-1:0]    raddr;
  logic [TIME_BITS-1:0] arr_q;
  logic [TIME_BITS-1:0] rem_q;

  scan_ctl_t scan_ctl;
  scan_res_t scan_res;

  tps_ram #(.DEPTH(MAX_SLOTS), .WIDTH(TIME_BITS)) u_arrival (
    .clk   (clk),
    .we    (arr_we),
    .waddr (arr_waddr),
    .wdata (in_arrival_tick),
    .raddr (raddr),
    .rdata (arr_q)
  );

  tps_ram #(.DEPTH(MAX_SLOTS), .WIDTH(TIME_BITS)) u_remaining (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (raddr),
    .rdata (rem_q)
  );

  tps_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .arr_q    (arr_q),
    .rem_q    (rem_q),
    .time_now (time_r),
    .res      (scan_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POL_FCFS;
      num_r     <= NSLOT_W'(1);
      quantum_r <= QUANTUM_W'(500);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY:    policy_r  <= cfg_data[POLICY_W-1:0];
        REG_NUM_SLOTS: num_r     <= cfg_data[NSLOT_W-1:0];
        REG_QUANTUM:   quantum_r <= cfg_data[QUANTUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_r == '0) begin
      n = CNT_W'(1);
    end else if (int'(num_r) > MAX_SLOTS) begin
      n = CNT_W'(MAX_SLOTS);
    end else begin
      n = CNT_W'(num_r);
    end
    q            = (quantum_r == '0) ? QUANTUM_W'(1) : quantum_r;
    all_done_now = (int'(done_r) >= int'(n));
  end

  always_comb begin
    state_nxt     = state_r;
    arrived_nxt   = arrived_r;
    time_nxt      = time_r;
    cv_nxt        = cv_r;
    cs_nxt        = cs_r;
    slice_nxt     = slice_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    ev_nxt        = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    m_nxt         = m_r;
    fin_valid_nxt = fin_valid_r;
    fin_slot_nxt  = fin_slot_r;

    strobe_nxt = 1'b0;
    rv_nxt     = rv_r;
    rs_nxt     = rs_r;
    fv_nxt     = fv_r;
    fs_nxt     = fs_r;
    ad_nxt     = ad_r;
    tn_nxt     = tn_r;

    arr_we    = 1'b0;
    rem_we    = 1'b0;
    arr_waddr = in_slot;
    rem_waddr = in_slot;
    rem_wdata = in_run_length;
    raddr     = cs_r;

    retiring   = 1'b0;
    done_after = done_r;
    pick_ok    = 1'b0;
    pick       = cs_r;
    slice_base = slice_r;

    scan_ctl.clr         = 1'b0;
    scan_ctl.ev          = 1'b0;
    scan_ctl.idx         = ev_idx_r;
    scan_ctl.arrived_old = arrived_r[ev_idx_r];
    scan_ctl.by_rem      = (policy_r == POL_SJF);
    scan_ctl.start       = m_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_command == CMD_LOAD) begin
            arr_we               = 1'b1;
            rem_we               = 1'b1;
            arrived_nxt[in_slot] = 1'b0;
            strobe_nxt           = 1'b1;
            rv_nxt               = 1'b0;
            rs_nxt               = '0;
            fv_nxt               = 1'b0;
            fs_nxt               = '0;
            ad_nxt               = all_done_now;
            tn_nxt               = time_r;
          end else begin
            raddr     = cs_r;
            state_nxt = S_RETIRE;
          end
        end
      end

      S_RETIRE: begin
        retiring      = cv_r && (rem_q == '0);
        fin_valid_nxt = retiring;
        fin_slot_nxt  = retiring ? cs_r : '0;
        if (retiring) begin
          cv_nxt     = 1'b0;
          done_after = (done_r != DONE_MAX) ? done_r + 1'b1 : done_r;
        end
        done_nxt = done_after;
        if (int'(done_after) >= int'(n)) begin
          state_nxt = S_REPORT;
        end else begin
          m_nxt        = CNT_W'(cs_r) + CNT_W'(1);
          idx_nxt      = '0;
          scan_ctl.clr = 1'b1;
          state_nxt    = S_MOD;
        end
      end

      // rotation start = (current slot + 1) mod n
      S_MOD: begin
        if (m_r >= n) begin
          m_nxt = m_r - n;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        raddr       = idx_r[SLOT_W-1:0];
        scan_ctl.ev = ev_r;
        if (ev_r) begin
          arrived_nxt[ev_idx_r] = scan_res.arrived_new;
        end
        if (idx_r < n) begin
          ev_nxt     = 1'b1;
          ev_idx_nxt = idx_r[SLOT_W-1:0];
          idx_nxt    = idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        unique case (policy_r) inside
          POL_FCFS, POL_SJF: begin
            if (cv_r) begin
              pick_ok = 1'b1;
              pick    = cs_r;
            end else begin
              pick_ok = scan_res.found;
              pick    = scan_res.best_idx;
            end
          end
          POL_RR: begin
            if (!cv_r) begin
              pick_ok = scan_res.any_found;
              pick    = scan_res.first_any;
            end else if (slice_r == '0) begin
              pick_ok = 1'b1;
              if (scan_res.ge_found) begin
                pick = scan_res.first_ge;
              end else if (scan_res.any_found) begin
                pick = scan_res.first_any;
              end else begin
                pick = cs_r;
              end
            end else begin
              pick_ok = 1'b1;
              pick    = cs_r;
            end
          end
          default: pick_ok = 1'b0;
        endcase
        if (pick_ok && (!cv_r || pick != cs_r)) begin
          cv_nxt     = 1'b1;
          cs_nxt     = pick;
          slice_base = '0;
        end
        if ({1'b0, slice_base} + 1'b1 >= {1'b0, q}) begin
          slice_nxt = '0;
        end else begin
          slice_nxt = slice_base + 1'b1;
        end
        raddr     = cs_nxt;
        state_nxt = S_UPD;
      end

      S_UPD: begin
        if (cv_r && rem_q != '0) begin
          rem_we    = 1'b1;
          rem_waddr = cs_r;
          rem_wdata = rem_q - 1'b1;
        end
        time_nxt   = (&time_r) ? time_r : time_r + 1'b1;
        strobe_nxt = 1'b1;
        rv_nxt     = cv_r;
        rs_nxt     = cv_r ? cs_r : '0;
        fv_nxt     = fin_valid_r;
        fs_nxt     = fin_slot_r;
        ad_nxt     = all_done_now;
        tn_nxt     = time_r;
        state_nxt  = S_IDLE;
      end

      S_REPORT: begin
        strobe_nxt = 1'b1;
        rv_nxt     = 1'b0;
        rs_nxt     = '0;
        fv_nxt     = fin_valid_r;
        fs_nxt     = fin_slot_r;
        ad_nxt     = all_done_now;
        tn_nxt     = time_r;
        state_nxt  = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arrived_r   <= '0;
      time_r      <= '0;
      cv_r        <= 1'b0;
      cs_r        <= '0;
      slice_r     <= '0;
      done_r      <= '0;
      idx_r       <= '0;
      ev_r        <= 1'b0;
      m_r         <= '0;
      fin_valid_r <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arrived_r   <= arrived_nxt;
      time_r      <= time_nxt;
      cv_r        <= cv_nxt;
      cs_r        <= cs_nxt;
      slice_r     <= slice_nxt;
      done_r      <= done_nxt;
      idx_r       <= idx_nxt;
      ev_r        <= ev_nxt;
      m_r         <= m_nxt;
      fin_valid_r <= fin_valid_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r   <= ev_idx_nxt;
    fin_slot_r <= fin_slot_nxt;
    rv_r       <= rv_nxt;
    rs_r       <= rs_nxt;
    fv_r       <= fv_nxt;
    fs_r       <= fs_nxt;
    ad_r       <= ad_nxt;
    tn_r       <= tn_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_strobe         = strobe_r;
  assign out_running_valid  = rv_r;
  assign out_running_slot   = rs_r;
  assign out_finished_valid = fv_r;
  assign out_finished_slot  = fs_r;
  assign out_all_done       = ad_r;
  assign out_time_now       = tn_r;

  `TPS_ASSERT_NXT(a_tick_goes_busy, start && !busy && in_command == CMD_TICK, busy && !out_strobe)
  `TPS_ASSERT_NXT(a_load_reports, start && !busy && in_command == CMD_LOAD,
                  out_strobe && !out_running_valid && !out_finished_valid)
  `TPS_ASSERT_NXT(a_final_strobes, state_r == S_UPD || state_r == S_REPORT, out_strobe && !busy)
  `TPS_ASSERT_IMP(a_run_not_done, out_strobe && out_running_valid, !out_all_done)
  `TPS_ASSERT_IMP(a_strobe_idle, out_strobe, state_r == S_IDLE)

endmodule

### design/tps_ram.sv
`timescale 1ns / 1ps

module tps_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/tps_scan.sv
`timescale 1ns / 1ps

module tps_scan import tps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scan_ctl_t            ctl,
  input  logic [TIME_BITS-1:0] arr_q,
  input  logic [TIME_BITS-1:0] rem_q,
  input  logic [TIME_BITS-1:0] time_now,
  output scan_res_t            res
);

  logic                 arrived_new;
  logic                 elig;
  logic [TIME_BITS-1:0] key;

  logic                 found_r;
  logic [TIME_BITS-1:0] best_key_r;
  logic [SLOT_W-1:0]    best_idx_r;
  logic                 any_r;
  logic [SLOT_W-1:0]    first_any_r;
  logic                 ge_r;
  logic [SLOT_W-1:0]    first_ge_r;

  always_comb begin
    arrived_new = ctl.arrived_old | (arr_q == time_now);
    elig        = arrived_new && (rem_q != '0);
    key         = ctl.by_rem ? rem_q : arr_q;
  end

  // one slot per cycle through the compare unit
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      found_r <= 1'b0;
      any_r   <= 1'b0;
      ge_r    <= 1'b0;
    end else if (ctl.ev && elig) begin
      if (!found_r || key < best_key_r) begin
        found_r    <= 1'b1;
        best_key_r <= key;
        best_idx_r <= ctl.idx;
      end
      if (!any_r) begin
        any_r       <= 1'b1;
        first_any_r <= ctl.idx;
      end
      if (!ge_r && CNT_W'(ctl.idx) >= ctl.start) begin
        ge_r       <= 1'b1;
        first_ge_r <= ctl.idx;
      end
    end
  end

  always_comb begin
    res.arrived_new = arrived_new;
    res.found       = found_r;
    res.best_idx    = best_idx_r;
    res.any_found   = any_r;
    res.first_any   = first_any_r;
    res.ge_found    = ge_r;
    res.first_ge    = first_ge_r;
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tps_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS = 1800;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic                 running_valid;
    logic [SLOT_W-1:0]    running_slot;
    logic                 finished_valid;
    logic [SLOT_W-1:0]    finished_slot;
    logic                 all_done;
    logic [TIME_BITS-1:0] time_now;
  } sched_result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                 cmd;
    logic [SLOT_W-1:0]    slot;
    logic [TIME_BITS-1:0] arr;
    logic [TIME_BITS-1:0] run;
    bit                   typed;
    sched_result_t        res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_command = CMD_LOAD;
  logic [SLOT_W-1:0]     in_slot = '0;
  logic [TIME_BITS-1:0]  in_arrival_tick = '0;
  logic [TIME_BITS-1:0]  in_run_length = '0;
  logic                  out_strobe;
  logic                  out_running_valid;
  logic [SLOT_W-1:0]     out_running_slot;
  logic                  out_finished_valid;
  logic [SLOT_W-1:0]     out_finished_slot;
  logic                  out_all_done;
  logic [TIME_BITS-1:0]  out_time_now;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tick_process_scheduler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_slot            (in_slot),
    .in_arrival_tick    (in_arrival_tick),
    .in_run_length      (in_run_length),
    .out_strobe         (out_strobe),
    .out_running_valid  (out_running_valid),
    .out_running_slot   (out_running_slot),
    .out_finished_valid (out_finished_valid),
    .out_finished_slot  (out_finished_slot),
    .out_all_done       (out_all_done),
    .out_time_now       (out_time_now),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler state as the testbench sees it
  logic [POLICY_W-1:0]  m_policy;
  logic [NSLOT_W-1:0]   m_nslots;
  logic [QUANTUM_W-1:0] m_quantum;
  logic [TIME_BITS-1:0] m_arrival [MAX_SLOTS];
  logic [TIME_BITS-1:0] m_remaining [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] m_arrived;
  logic [TIME_BITS-1:0] m_time;
  logic                 m_cur_valid;
  logic [SLOT_W-1:0]    m_cur_slot;
  logic [QUANTUM_W-1:0] m_slice;
  logic [DONE_W-1:0]    m_done;

  sched_result_t pending_results [$];
  dir_row_t      dir_rows [$];
  int            mismatches = 0;
  int            cycle_cnt = 0;
  int            items_sent = 0;
  int            stop_at = 32'h7fff_ffff;
  bit            idle_ok = 1'b1;

  function automatic sched_result_t sched_step(input logic cmd, input logic [SLOT_W-1:0] slot,
                                               input logic [TIME_BITS-1:0] arr,
                                               input logic [TIME_BITS-1:0] run);
    sched_result_t        r;
    int                   n;
    int                   q;
    int                   i;
    int                   k;
    int                   idx;
    logic                 ok;
    logic [SLOT_W-1:0]    pick;
    logic [TIME_BITS-1:0] best;
    logic [TIME_BITS-1:0] key;
    r = '0;
    r.time_now = m_time;
    n = (m_nslots == 0) ? 1 : ((m_nslots > MAX_SLOTS) ? MAX_SLOTS : int'(m_nslots));
    q = (m_quantum == 0) ? 1 : int'(m_quantum);
    best = '0;
    if (cmd == CMD_LOAD) begin
      m_arrival[slot] = arr;
      m_remaining[slot] = run;
      m_arrived[slot] = 1'b0;
      r.all_done = (int'(m_done) >= n);
      return r;
    end
    // retire the running slot
    if (m_cur_valid && m_remaining[m_cur_slot] == 0) begin
      r.finished_valid = 1'b1;
      r.finished_slot = m_cur_slot;
      m_cur_valid = 1'b0;
      if (m_done != DONE_MAX) m_done = m_done + 1'b1;
    end
    if (int'(m_done) < n) begin
      for (i = 0; i < n; i++)
        if (m_arrival[i] == m_time) m_arrived[i] = 1'b1;
      ok = 1'b0;
      pick = '0;
      if (m_policy == POL_FCFS || m_policy == POL_SJF) begin
        if (m_cur_valid) begin
          ok = 1'b1;
          pick = m_cur_slot;
        end else begin
          for (i = 0; i < n; i++) begin
            if (m_arrived[i] && m_remaining[i] != 0) begin
              key = (m_policy == POL_SJF) ? m_remaining[i] : m_arrival[i];
              if (!ok || key < best) begin
                ok = 1'b1;
                best = key;
                pick = SLOT_W'(i);
              end
            end
          end
        end
      end else if (m_policy == POL_RR) begin
        if (!m_cur_valid) begin
          for (i = 0; i < n && !ok; i++)
            if (m_arrived[i] && m_remaining[i] != 0) begin
              ok = 1'b1;
              pick = SLOT_W'(i);
            end
        end else if (m_slice == 0) begin
          for (k = 1; k <= n && !ok; k++) begin
            idx = (int'(m_cur_slot) + k) % n;
            if (m_arrived[idx] && m_remaining[idx] != 0) begin
              ok = 1'b1;
              pick = SLOT_W'(idx);
            end
          end
          if (!ok) begin
            ok = 1'b1;
            pick = m_cur_slot;
          end
        end else begin
          ok = 1'b1;
          pick = m_cur_slot;
        end
      end
      if (ok && (!m_cur_valid || pick != m_cur_slot)) begin
        m_cur_valid = 1'b1;
        m_cur_slot = pick;
        m_slice = '0;
      end
      if (m_cur_valid) begin
        r.running_valid = 1'b1;
        r.running_slot = m_cur_slot;
      end
      // advance time
      if (m_time != TIME_MAX) m_time = m_time + 1'b1;
      if (int'(m_slice) + 1 >= q) m_slice = '0;
      else m_slice = m_slice + 1'b1;
      if (m_cur_valid && m_remaining[m_cur_slot] != 0)
        m_remaining[m_cur_slot] = m_remaining[m_cur_slot] - 1'b1;
    end
    r.all_done = (int'(m_done) >= n);
    return r;
  endfunction

  function automatic sched_result_t mk_res(input logic rv, input logic [SLOT_W-1:0] rs,
                                           input logic fv, input logic [SLOT_W-1:0] fs,
                                           input logic ad, input logic [TIME_BITS-1:0] tn);
    return {rv, rs, fv, fs, ad, tn};
  endfunction

  function automatic void cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{kind: ROW_CFG, default: '0};
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endfunction

  function automatic void item_row(input logic cmd, input logic [SLOT_W-1:0] slot,
                                   input logic [TIME_BITS-1:0] arr,
                                   input logic [TIME_BITS-1:0] run,
                                   input bit typed, input sched_result_t res);
    dir_row_t row;
    row = '{kind: ROW_ITEM, default: '0};
    row.kind = ROW_ITEM;
    row.cmd = cmd;
    row.slot = slot;
    row.arr = arr;
    row.run = run;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] base,
                                                   input int unsigned delta);
    if (int'(TIME_MAX - base) < int'(delta)) return TIME_MAX;
    return base + TIME_BITS'(delta);
  endfunction

  // keep retirements rare once many slots have finished
  function automatic logic [TIME_BITS-1:0] pick_run();
    if (m_done < 11 && $urandom_range(0, 4) == 0) return TIME_BITS'($urandom_range(1, 6));
    if (m_done < 11) return TIME_BITS'($urandom_range(30, 500));
    return TIME_BITS'($urandom_range(2000, 20000));
  endfunction

  task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                           input logic [TIME_BITS-1:0] arr, input logic [TIME_BITS-1:0] run,
                           input bit typed, input sched_result_t typed_res);
    int            gap;
    sched_result_t r;
    gap = 0;
    if (idle_ok && items_sent + 300 < stop_at && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_slot <= slot;
    in_arrival_tick <= arr;
    in_run_length <= run;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = sched_step(cmd, slot, arr, run);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_POLICY:    m_policy = val[POLICY_W-1:0];
      REG_NUM_SLOTS: m_nslots = val[NSLOT_W-1:0];
      REG_QUANTUM:   m_quantum = val[QUANTUM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: no result pending");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        compare_field("running_valid", 32'(e.running_valid), 32'(out_running_valid));
        compare_field("running_slot", 32'(e.running_slot), 32'(out_running_slot));
        compare_field("finished_valid", 32'(e.finished_valid), 32'(out_finished_valid));
        compare_field("finished_slot", 32'(e.finished_slot), 32'(out_finished_slot));
        compare_field("all_done", 32'(e.all_done), 32'(out_all_done));
        compare_field("time_now", 32'(e.time_now), 32'(out_time_now));
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int                    phase_len;
    bit                    first_phase;
    logic [CFG_DATA_W-1:0] qv;
    logic [SLOT_W-1:0]     sl;
    logic [TIME_BITS-1:0]  arr;
    logic [TIME_BITS-1:0]  run;

    m_policy = POL_FCFS;
    m_nslots = NSLOT_W'(1);
    m_quantum = QUANTUM_W'(500);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      m_arrival[i] = '0;
      m_remaining[i] = '0;
    end
    m_arrived = '0;
    m_time = '0;
    m_cur_valid = 1'b0;
    m_cur_slot = '0;
    m_slice = '0;
    m_done = '0;

    // one slot, first come first served, runs two ticks and retires
    item_row(CMD_LOAD, 4'd0, 24'd0, 24'd2, 1'b1, mk_res(0, 0, 0, 0, 0, 24'd0));
    item_row(CMD_TICK, 4'd0, 24'd0, 24'd0, 1'b1, mk_res(1, 0, 0, 0, 0, 24'd0));
    item_row(CMD_TICK, 4'd0, 24'd0, 24'd0, 1'b1, mk_res(1, 0, 0, 0, 0, 24'd1));
    item_row(CMD_TICK, 4'd0, 24'd0, 24'd0, 1'b1, mk_res(0, 0, 1, 0, 1, 24'd2));
    // all done: time frozen
    item_row(CMD_TICK, 4'hf, TIME_MAX, TIME_MAX, 1'b1, mk_res(0, 0, 0, 0, 1, 24'd2));
    cfg_row(REG_POLICY, CFG_DATA_W'(POL_SJF));
    cfg_row(REG_NUM_SLOTS, CFG_DATA_W'(4));
    item_row(CMD_LOAD, 4'hf, TIME_MAX, TIME_MAX, 1'b1, mk_res(0, 0, 0, 0, 0, 24'd2));
    item_row(CMD_LOAD, 4'd0, 24'd3, 24'd5, 1'b0, '0);
    item_row(CMD_LOAD, 4'd1, 24'd3, 24'd2, 1'b0, '0);
    item_row(CMD_LOAD, 4'd2, 24'd4, 24'd1, 1'b0, '0);
    item_row(CMD_LOAD, 4'd3, TIME_MAX, 24'd3, 1'b0, '0);
    repeat (5) item_row(CMD_TICK, 4'd0, 24'd0, 24'd0, 1'b0, '0);
    cfg_row(REG_POLICY, CFG_DATA_W'(POL_RR));
    cfg_row(REG_QUANTUM, CFG_DATA_W'(1));
    item_row(CMD_LOAD, 4'd1, 24'd7, 24'd3, 1'b0, '0);
    item_row(CMD_LOAD, 4'd2, 24'd7, 24'd3, 1'b0, '0);
    repeat (4) item_row(CMD_TICK, 4'd0, 24'd0, 24'd0, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_cfg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else
        send_item(dir_rows[i].cmd, dir_rows[i].slot, dir_rows[i].arr, dir_rows[i].run,
                  dir_rows[i].typed, dir_rows[i].res);
    end

    stop_at = items_sent + RAND_ITEMS;
    first_phase = 1'b1;
    while (items_sent < stop_at) begin
      write_cfg(REG_POLICY, CFG_DATA_W'($urandom_range(0, 2)));
      write_cfg(REG_NUM_SLOTS,
                CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 16));
      case ($urandom_range(0, 5))
        0:       qv = CFG_DATA_W'(1);
        1:       qv = CFG_DATA_W'(65535);
        2:       qv = CFG_DATA_W'($urandom_range(2, 6));
        3:       qv = CFG_DATA_W'($urandom_range(1, 40));
        4:       qv = CFG_DATA_W'(500);
        default: qv = CFG_DATA_W'($urandom_range(1, 65535));
      endcase
      write_cfg(REG_QUANTUM, qv);
      idle_ok = ($urandom_range(0, 3) != 0);
      // well-formed reload: every slot, arrivals nondecreasing from now
      if (first_phase || $urandom_range(0, 1) == 0) begin
        arr = sat_add(m_time, $urandom_range(0, 5));
        for (int s = 0; s < MAX_SLOTS; s++) begin
          send_item(CMD_LOAD, SLOT_W'(s), arr, pick_run(), 1'b0, '0);
          arr = sat_add(arr, $urandom_range(0, 8));
        end
      end
      first_phase = 1'b0;
      phase_len = $urandom_range(40, 120);
      for (int j = 0; j < phase_len && items_sent < stop_at; j++) begin
        sl = SLOT_W'($urandom);
        if ($urandom_range(0, 99) < 85) begin
          send_item(CMD_TICK, sl, TIME_BITS'($urandom), TIME_BITS'($urandom), 1'b0, '0);
        end else begin
          if ($urandom_range(0, 9) == 0) begin
            arr = TIME_BITS'($urandom);
            run = TIME_BITS'($urandom);
            if (run == 0) run = TIME_BITS'(1);
          end else begin
            arr = sat_add(m_time, $urandom_range(0, 30));
            run = pick_run();
          end
          send_item(CMD_LOAD, sl, arr, run, 1'b0, '0);
        end
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
